@@ rtl/bdb_pkg.sv @@
package bdb_pkg;

    localparam int CFG_BITS        = 24;
    localparam int CFG_INDEX_BITS  = 2;
    localparam int TIMER_BITS_DEF  = 24;
    localparam int PIN_COUNT_DEF   = 5;
    localparam int REPORT_BITS     = 3;

    localparam logic [CFG_INDEX_BITS-1:0] REG_SAMPLE       = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DEBOUNCE     = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PRESS_TONE   = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RELEASE_TONE = 2'd3;

    localparam logic [CFG_BITS-1:0] SAMPLE_RESET       = 24'd10;
    localparam logic [CFG_BITS-1:0] DEBOUNCE_RESET     = 24'd100;
    localparam logic [CFG_BITS-1:0] PRESS_TONE_RESET   = 24'd2000;
    localparam logic [CFG_BITS-1:0] RELEASE_TONE_RESET = 24'd5000;

    localparam logic [4:0] PAT_SELECT = 5'h0F;
    localparam logic [4:0] PAT_RIGHT  = 5'h17;
    localparam logic [4:0] PAT_LEFT   = 5'h1B;
    localparam logic [4:0] PAT_DOWN   = 5'h1D;
    localparam logic [4:0] PAT_UP     = 5'h1E;

    localparam logic [REPORT_BITS-1:0] CODE_NONE   = 3'd0;
    localparam logic [REPORT_BITS-1:0] CODE_SELECT = 3'd1;
    localparam logic [REPORT_BITS-1:0] CODE_RIGHT  = 3'd2;
    localparam logic [REPORT_BITS-1:0] CODE_LEFT   = 3'd3;
    localparam logic [REPORT_BITS-1:0] CODE_DOWN   = 3'd4;
    localparam logic [REPORT_BITS-1:0] CODE_UP     = 3'd5;

    typedef struct packed {
        logic                   tone;
        logic [REPORT_BITS-1:0] button_report;
    } result_t;

    function automatic logic [REPORT_BITS-1:0] pattern_code(input logic [4:0] p);
        logic [REPORT_BITS-1:0] code;
        unique case (p)
            PAT_SELECT: code = CODE_SELECT;
            PAT_RIGHT:  code = CODE_RIGHT;
            PAT_LEFT:   code = CODE_LEFT;
            PAT_DOWN:   code = CODE_DOWN;
            PAT_UP:     code = CODE_UP;
            default:    code = CODE_NONE;
        endcase
        return code;
    endfunction

endpackage

@@ rtl/button_debounce_beep_fsm_core.sv @@
// Button debounce and beep controller. Each accepted request is one timer tick carrying the
// five active-low button pins; the pins are resampled every sample_period ticks and a
// four-phase machine (idle, debounce, pushed, released) confirms a press, sounds the tone
// for the press and release periods and, on the tick the release tone ends, reports a
// single-button pattern as a code (1 select .. 5 up, 0 otherwise). Every request gives
// exactly one result. A request is taken every clock cycle: the whole tick update is one
// pass of logic into the state registers, and its result lands in a two-entry output
// buffer, which registers it; input stalls only when both buffer entries are waiting.
// Registers are written through cfg_wr_en, cfg_index and cfg_data and should only change
// while the block is idle.
module button_debounce_beep_fsm_core
    import bdb_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF,
    parameter int PIN_COUNT  = PIN_COUNT_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]       cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [PIN_COUNT-1:0]      pins,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      tone,
    output logic [REPORT_BITS-1:0]    button_report
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_DEBOUNCE,
        PH_PUSHED,
        PH_RELEASED
    } phase_t;

    localparam logic [PIN_COUNT-1:0] ALL_RELEASED = {PIN_COUNT{1'b1}};

    function automatic logic [TIMER_BITS-1:0] fit(input logic [CFG_BITS-1:0] v);
        logic [TIMER_BITS+CFG_BITS-1:0] wide;
        wide = {{TIMER_BITS{1'b0}}, v};
        return wide[TIMER_BITS-1:0];
    endfunction

    logic [CFG_BITS-1:0]   sample_period_reg;
    logic [CFG_BITS-1:0]   debounce_period_reg;
    logic [CFG_BITS-1:0]   press_tone_period_reg;
    logic [CFG_BITS-1:0]   release_tone_period_reg;

    phase_t                phase_reg,            phase_next;
    logic [TIMER_BITS-1:0] sample_countdown_reg, sample_countdown_next;
    logic [PIN_COUNT-1:0]  held_pins_reg,        held_pins_next;
    logic [TIMER_BITS-1:0] phase_countdown_reg,  phase_countdown_next;
    logic [PIN_COUNT-1:0]  latched_pattern_reg,  latched_pattern_next;
    logic                  tone_on_reg,          tone_on_next;

    logic [TIMER_BITS-1:0] phase_dec;
    logic                  expired;
    logic                  accept;
    result_t               result;
    result_t               out_data;

    assign accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_period_reg       <= SAMPLE_RESET;
            debounce_period_reg     <= DEBOUNCE_RESET;
            press_tone_period_reg   <= PRESS_TONE_RESET;
            release_tone_period_reg <= RELEASE_TONE_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_SAMPLE:       sample_period_reg       <= cfg_data;
                REG_DEBOUNCE:     debounce_period_reg     <= cfg_data;
                REG_PRESS_TONE:   press_tone_period_reg   <= cfg_data;
                REG_RELEASE_TONE: release_tone_period_reg <= cfg_data;
            endcase
        end
    end

    always_comb
    begin
        sample_countdown_next = sample_countdown_reg;
        held_pins_next        = held_pins_reg;
        phase_next            = phase_reg;
        phase_countdown_next  = phase_countdown_reg;
        latched_pattern_next  = latched_pattern_reg;
        tone_on_next          = tone_on_reg;
        result.button_report  = CODE_NONE;

        if (sample_countdown_reg == '0)
        begin
            held_pins_next = pins;
            if (sample_period_reg == '0)
            begin
                sample_countdown_next = '0;
            end
            else
            begin
                sample_countdown_next = fit(sample_period_reg - CFG_BITS'(1));
            end
        end
        else
        begin
            sample_countdown_next = sample_countdown_reg - TIMER_BITS'(1);
        end

        phase_dec = (phase_countdown_reg == '0) ? '0 : phase_countdown_reg - TIMER_BITS'(1);
        expired   = (phase_dec == '0);

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (held_pins_next != ALL_RELEASED)
                begin
                    phase_next           = PH_DEBOUNCE;
                    phase_countdown_next = fit(debounce_period_reg);
                end
            end
            PH_DEBOUNCE:
            begin
                phase_countdown_next = phase_dec;
                if (expired)
                begin
                    if (held_pins_next != ALL_RELEASED)
                    begin
                        phase_next           = PH_PUSHED;
                        phase_countdown_next = fit(press_tone_period_reg);
                        tone_on_next         = 1'b1;
                        latched_pattern_next = held_pins_next;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
            end
            PH_PUSHED:
            begin
                phase_countdown_next = phase_dec;
                if (expired)
                begin
                    tone_on_next = 1'b0;
                    if (held_pins_next == ALL_RELEASED)
                    begin
                        phase_next           = PH_RELEASED;
                        phase_countdown_next = fit(release_tone_period_reg);
                        tone_on_next         = 1'b1;
                    end
                end
            end
            PH_RELEASED:
            begin
                phase_countdown_next = phase_dec;
                if (expired)
                begin
                    tone_on_next         = 1'b0;
                    phase_next           = PH_IDLE;
                    result.button_report = pattern_code(5'(latched_pattern_reg));
                end
            end
        endcase

        result.tone = tone_on_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg            <= PH_IDLE;
            sample_countdown_reg <= '0;
            held_pins_reg        <= ALL_RELEASED;
            phase_countdown_reg  <= '0;
            latched_pattern_reg  <= ALL_RELEASED;
            tone_on_reg          <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg            <= phase_next;
            sample_countdown_reg <= sample_countdown_next;
            held_pins_reg        <= held_pins_next;
            phase_countdown_reg  <= phase_countdown_next;
            latched_pattern_reg  <= latched_pattern_next;
            tone_on_reg          <= tone_on_next;
        end
    end

    bdb_skid u_skid (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (in_valid),
        .push_ready (in_ready),
        .push_data  (result),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

    assign tone          = out_data.tone;
    assign button_report = out_data.button_report;

endmodule

@@ rtl/bdb_skid.sv @@
module bdb_skid
    import bdb_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push_valid,
    output logic    push_ready,
    input  result_t push_data,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    head_valid_reg;
    logic    spare_valid_reg;
    result_t head_reg;
    result_t spare_reg;
    logic    push;
    logic    pop;

    assign push_ready = !spare_valid_reg;
    assign push       = push_valid && push_ready;
    assign pop        = head_valid_reg && out_ready;
    assign out_valid  = head_valid_reg;
    assign out_data   = head_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg  <= 1'b0;
            spare_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (spare_valid_reg)
            begin
                head_reg        <= spare_reg;
                spare_valid_reg <= 1'b0;
            end
            else if (push)
            begin
                head_reg <= push_data;
            end
            else
            begin
                head_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (head_valid_reg)
            begin
                spare_reg       <= push_data;
                spare_valid_reg <= 1'b1;
            end
            else
            begin
                head_reg       <= push_data;
                head_valid_reg <= 1'b1;
            end
        end
    end

endmodule
